FILE: hw/rtl/cu_pkg.sv
// Package for the combination unranker: widths, register indexes, the queue
// entry, the binomial row type and the back-end state encoding.
// No dependencies.
package cu_pkg;

    localparam int MAX_UNIVERSE = 64;
    localparam int MAX_SUBSET   = 16;

    // Fixed field widths of the ports
    localparam int RANK_W  = 61;
    localparam int UNIV_W  = 7;
    localparam int SUB_W   = 5;
    localparam int POS_W   = 4;
    localparam int VAL_W   = 7;
    localparam int CIDX_W  = 4;
    localparam int CDATA_W = 8;

    // Binomial table: one row per n in 0..MAX_UNIVERSE, entries r in 0..MAX_SUBSET
    localparam int BINOM_W   = 64;
    localparam int ROWS      = MAX_UNIVERSE + 1;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int ENTRIES   = MAX_SUBSET + 1;

    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_UNIVERSE = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_SUBSET   = CIDX_W'(1);

    localparam logic [UNIV_W-1:0] UNIVERSE_RST = UNIV_W'(49);
    localparam logic [SUB_W-1:0]  SUBSET_RST   = SUB_W'(6);

    typedef logic [BINOM_W-1:0] binom_t;
    typedef binom_t [ENTRIES-1:0] binom_row_t;

    // One queued rank with the configuration it was accepted under
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [UNIV_W-1:0] universe;
        logic [SUB_W-1:0]  subset;
        logic              cfg_bad;
    } job_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_FAIL
    } back_state_t;

endpackage

FILE: hw/rtl/cu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/cu_front.sv
// Front end: configuration registers, input acceptance and classification of
// each rank against the configuration. Depends on cu_pkg.
module cu_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cu_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [cu_pkg::CDATA_W-1:0]  cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [cu_pkg::RANK_W-1:0]   s_rank,
    input  logic                        init_done,
    input  logic                        q_full,
    output logic                        push_valid,
    output cu_pkg::job_t                push_job
);

    logic [cu_pkg::UNIV_W-1:0] universe_reg;
    logic [cu_pkg::SUB_W-1:0]  subset_reg;
    logic                      cfg_bad;

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            universe_reg <= cu_pkg::UNIVERSE_RST;
            subset_reg   <= cu_pkg::SUBSET_RST;
        end else if (cfg_valid) begin
            if (cfg_index == cu_pkg::CFG_UNIVERSE) begin
                universe_reg <= cfg_data[cu_pkg::UNIV_W-1:0];
            end else if (cfg_index == cu_pkg::CFG_SUBSET) begin
                subset_reg <= cfg_data[cu_pkg::SUB_W-1:0];
            end
        end
    end

    // Configuration checks that need no binomial
    always_comb begin
        cfg_bad = (subset_reg == '0) ||
                  (subset_reg > cu_pkg::SUB_W'(cu_pkg::MAX_SUBSET)) ||
                  (universe_reg == '0) ||
                  (universe_reg > cu_pkg::UNIV_W'(cu_pkg::MAX_UNIVERSE)) ||
                  ({2'b00, subset_reg} > universe_reg);
    end

    // Take ranks only once the table is filled and the queue has room
    assign s_ready    = init_done && !q_full;
    assign push_valid = s_valid && s_ready;

    always_comb begin
        push_job.rank     = s_rank;
        push_job.universe = universe_reg;
        push_job.subset   = subset_reg;
        push_job.cfg_bad  = cfg_bad;
    end

endmodule

FILE: hw/rtl/cu_queue.sv
// Short job queue between front and back end.
// Depends on cu_pkg.
module cu_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    input  cu_pkg::job_t push_job,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output cu_pkg::job_t head_job
);

    localparam int PTR_W = $clog2(cu_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(cu_pkg::QUEUE_DEPTH + 1);

    cu_pkg::job_t     entry_reg [cu_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(cu_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Pointer and count update with wrap at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_valid) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(cu_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(cu_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push_valid) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: hw/rtl/cu_back.sv
// Back end: fills the binomial row table after reset, then walks candidates
// one table row per cycle unless the output is stalled, and drives the result register.
// Depends on cu_pkg and cu_ram.
module cu_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       head_valid,
    input  cu_pkg::job_t               head_job,
    output logic                       pop,
    output logic                       init_done,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [cu_pkg::POS_W-1:0]   m_element_position,
    output logic [cu_pkg::VAL_W-1:0]   m_element_value,
    output logic                       m_rank_error,
    output logic                       m_last
);

    cu_pkg::back_state_t        state_reg, state_next;
    logic [cu_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [cu_pkg::SUB_W-1:0]   s_reg, s_next;
    logic [cu_pkg::RANK_W-1:0]  rank_reg, rank_next;
    logic [cu_pkg::ROW_W-1:0]   fill_cnt_reg, fill_cnt_next;
    cu_pkg::binom_row_t         pascal_reg, pascal_next;

    logic                       ram_we, ram_re;
    logic [cu_pkg::ROW_W-1:0]   ram_raddr;
    cu_pkg::binom_row_t         ram_rdata;

    logic [cu_pkg::SUB_W-1:0]   entry_sel;
    cu_pkg::binom_t             binom;
    logic [cu_pkg::BINOM_W:0]   diff;
    logic                       borrow;
    logic [cu_pkg::ROW_W-1:0]   row_dec;

    logic                       out_valid_reg, out_valid_next;
    logic [cu_pkg::POS_W-1:0]   pos_reg;
    logic [cu_pkg::VAL_W-1:0]   val_reg;
    logic                       err_reg, last_reg;
    logic                       out_free;
    logic                       emit;
    logic [cu_pkg::POS_W-1:0]   emit_pos;
    logic [cu_pkg::VAL_W-1:0]   emit_val;
    logic                       emit_err, emit_last;

    cu_ram #(
        .WIDTH ($bits(cu_pkg::binom_row_t)),
        .DEPTH (cu_pkg::ROWS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (fill_cnt_reg),
        .wdata (pascal_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next Pascal row, truncated at r = MAX_SUBSET
    always_comb begin
        pascal_next[0] = cu_pkg::BINOM_W'(1);
        for (int j = 1; j < cu_pkg::ENTRIES; j++) begin
            pascal_next[j] = pascal_reg[j] + pascal_reg[j-1];
        end
    end

    // The check reads C(m,k); the walk reads C(i-1,s-1) from row i-1
    assign entry_sel = (state_reg == cu_pkg::ST_CHECK) ? s_reg : s_reg - cu_pkg::SUB_W'(1);
    assign binom     = ram_rdata[entry_sel];
    assign diff      = {1'b0, {(cu_pkg::BINOM_W - cu_pkg::RANK_W){1'b0}}, rank_reg}
                     - {1'b0, binom};
    assign borrow    = diff[cu_pkg::BINOM_W];
    assign row_dec   = row_reg - cu_pkg::ROW_W'(1);
    assign out_free  = !out_valid_reg || m_ready;
    assign init_done = (state_reg != cu_pkg::ST_INIT);

    // Next state, table port and result selection
    always_comb begin
        state_next    = state_reg;
        row_next      = row_reg;
        s_next        = s_reg;
        rank_next     = rank_reg;
        fill_cnt_next = fill_cnt_reg;
        pop           = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = row_dec;
        emit          = 1'b0;
        emit_pos      = '0;
        emit_val      = '0;
        emit_err      = 1'b1;
        emit_last     = 1'b1;
        unique case (state_reg)
            cu_pkg::ST_INIT: begin
                ram_we = 1'b1;
                if (fill_cnt_reg == cu_pkg::ROW_W'(cu_pkg::MAX_UNIVERSE)) begin
                    state_next = cu_pkg::ST_IDLE;
                end else begin
                    fill_cnt_next = fill_cnt_reg + cu_pkg::ROW_W'(1);
                end
            end
            cu_pkg::ST_IDLE: begin
                if (head_valid) begin
                    pop       = 1'b1;
                    rank_next = head_job.rank;
                    s_next    = head_job.subset;
                    row_next  = head_job.universe[cu_pkg::ROW_W-1:0];
                    if (head_job.cfg_bad) begin
                        state_next = cu_pkg::ST_FAIL;
                    end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = head_job.universe[cu_pkg::ROW_W-1:0];
                        state_next = cu_pkg::ST_CHECK;
                    end
                end
            end
            cu_pkg::ST_CHECK: begin
                if (!borrow) begin
                    // rank >= C(m,k)
                    if (out_free) begin
                        emit       = 1'b1;
                        state_next = cu_pkg::ST_IDLE;
                    end
                end else begin
                    ram_re     = 1'b1;
                    row_next   = row_dec;
                    state_next = cu_pkg::ST_WALK;
                end
            end
            cu_pkg::ST_WALK: begin
                if (borrow) begin
                    // C(i-1,s-1) > rank: candidate i fills slot s-1
                    if (out_free) begin
                        emit      = 1'b1;
                        emit_pos  = cu_pkg::POS_W'(s_reg - cu_pkg::SUB_W'(1));
                        emit_val  = cu_pkg::VAL_W'(row_reg) + cu_pkg::VAL_W'(1);
                        emit_err  = 1'b0;
                        emit_last = (s_reg == cu_pkg::SUB_W'(1));
                        s_next    = s_reg - cu_pkg::SUB_W'(1);
                        if (s_reg == cu_pkg::SUB_W'(1)) begin
                            state_next = cu_pkg::ST_IDLE;
                        end else begin
                            ram_re   = 1'b1;
                            row_next = row_dec;
                        end
                    end
                end else begin
                    rank_next = diff[cu_pkg::RANK_W-1:0];
                    ram_re    = 1'b1;
                    row_next  = row_dec;
                end
            end
            cu_pkg::ST_FAIL: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = cu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cu_pkg::ST_IDLE;
            end
        endcase
    end

    // Result register valid
    always_comb begin
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cu_pkg::ST_INIT;
            fill_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_cnt_reg  <= fill_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pascal row seed is part of the fill sequence, so it resets with it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pascal_reg <= {{((cu_pkg::ENTRIES - 1) * cu_pkg::BINOM_W){1'b0}},
                           cu_pkg::BINOM_W'(1)};
        end else if (state_reg == cu_pkg::ST_INIT) begin
            pascal_reg <= pascal_next;
        end
    end

    // Walk datapath and result payload
    always_ff @(posedge aclk) begin
        row_reg  <= row_next;
        s_reg    <= s_next;
        rank_reg <= rank_next;
        if (emit) begin
            pos_reg  <= emit_pos;
            val_reg  <= emit_val;
            err_reg  <= emit_err;
            last_reg <= emit_last;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_element_position = pos_reg;
    assign m_element_value    = val_reg;
    assign m_rank_error       = err_reg;
    assign m_last             = last_reg;

endmodule

FILE: hw/rtl/combination_unranker.sv
// Combination unranker: a rank with k elements is walked in the back end with one
// binomial table row read per candidate.
// Results wait in an output register while the queue keeps taking ranks.
// After reset the binomial table is filled, MAX_UNIVERSE + 1 = 65 rows, with
// s_ready low; configuration writes are taken throughout.
module combination_unranker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cu_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [cu_pkg::CDATA_W-1:0]  cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [cu_pkg::RANK_W-1:0]   s_rank,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cu_pkg::POS_W-1:0]    m_element_position,
    output logic [cu_pkg::VAL_W-1:0]    m_element_value,
    output logic                        m_rank_error,
    output logic                        m_last
);

    logic         init_done;
    logic         q_full;
    logic         push_valid;
    cu_pkg::job_t push_job;
    logic         pop;
    logic         head_valid;
    cu_pkg::job_t head_job;

    cu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rank     (s_rank),
        .init_done  (init_done),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    cu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    cu_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .head_valid         (head_valid),
        .head_job           (head_job),
        .pop                (pop),
        .init_done          (init_done),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_element_position (m_element_position),
        .m_element_value    (m_element_value),
        .m_rank_error       (m_rank_error),
        .m_last             (m_last)
    );

endmodule

FILE: hw/rtl/cu_checker.sv
// Port-level checks for combination_unranker, bound to the top level.
// Depends on cu_pkg.
module cu_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [cu_pkg::POS_W-1:0]   m_element_position,
    input logic [cu_pkg::VAL_W-1:0]   m_element_value,
    input logic                       m_rank_error,
    input logic                       m_last
);

    // A stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_element_position) &&
        $stable(m_element_value) && $stable(m_rank_error) && $stable(m_last))
        else $error("result changed while stalled");

    // Error results end the rank
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rank_error |-> m_last && m_element_value == '0)
        else $error("error result not final");

    // Element in slot p is at least p + 1
    a_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rank_error |->
        m_element_value > {{(cu_pkg::VAL_W - cu_pkg::POS_W){1'b0}}, m_element_position})
        else $error("element below its slot");

    // Final element sits in slot zero
    a_last_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rank_error && m_last |-> m_element_position == '0)
        else $error("final element not in slot zero");

    // Reset empties the result register
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind combination_unranker cu_checker u_cu_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_element_position (m_element_position),
    .m_element_value    (m_element_value),
    .m_rank_error       (m_rank_error),
    .m_last             (m_last)
);
